// File: rtl/core/ted_pkg.sv
// Shared types and constants for the text encoding decoder.
// No dependencies; every other file of the block imports this package.
package ted_pkg;

  localparam int CODE_W   = 21;
  localparam int BYTE_W   = 8;
  localparam int LEFT_W   = 3;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 8;

  // Result queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Encoding codes
  localparam logic [7:0] ENC_LATIN1    = 8'd0;
  localparam logic [7:0] ENC_UTF16_BOM = 8'd1;
  localparam logic [7:0] ENC_UTF16_BE  = 8'd2;
  localparam logic [7:0] ENC_UTF8      = 8'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_ENCODING = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPLIT    = 1'b1;

  localparam logic [7:0] UTF8_CONT_MASK  = 8'hc0;
  localparam logic [7:0] UTF8_CONT_TAG   = 8'h80;
  localparam logic [7:0] UTF8_LEAD2_MASK = 8'he0;
  localparam logic [7:0] UTF8_LEAD2_TAG  = 8'hc0;
  localparam logic [7:0] UTF8_LEAD3_MASK = 8'hf0;
  localparam logic [7:0] UTF8_LEAD3_TAG  = 8'he0;
  localparam logic [7:0] UTF8_LEAD4_MASK = 8'hf8;
  localparam logic [7:0] UTF8_LEAD4_TAG  = 8'hf0;

  localparam logic [CODE_W-1:0] SUPP_BASE = 21'h10000;
  localparam logic [CODE_W-1:0] BMP_MAX   = 21'h0ffff;
  localparam logic [CODE_W-1:0] HI_SURR   = 21'h0d800;
  localparam logic [CODE_W-1:0] LO_SURR   = 21'h0dc00;
  localparam logic [15:0]       UNIT_BOM  = 16'hfeff;
  localparam logic [15:0]       UNIT_NONCHAR = 16'hfffe;
  localparam logic [7:0]        BOM_HI    = 8'hfe;
  localparam logic [7:0]        BOM_LO    = 8'hff;

  typedef struct packed {
    logic [7:0] encoding;
    logic       split;
  } cfg_t;

  // One decoded byte's worth of results: one unit, or a surrogate pair
  typedef struct packed {
    logic              pair;
    logic [CODE_W-1:0] unit0;
    logic [CODE_W-1:0] unit1;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// File: rtl/core/ted_if.sv
// Valid/ready channel interfaces for raw bytes in and code units out.
// Depends on ted_pkg for field widths.
interface ted_in_if import ted_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic [LEFT_W-1:0] bytes_left;

  modport source (output valid, output data_byte, output bytes_left, input ready);
  modport sink   (input valid, input data_byte, input bytes_left, output ready);
endinterface

interface ted_out_if import ted_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] code_unit;
  logic              last_of_run;

  modport source (output valid, output code_unit, output last_of_run, input ready);
  modport sink   (input valid, input code_unit, input last_of_run, output ready);
endinterface

// File: rtl/core/text_encoding_decoder.sv
// Text encoding decoder: Latin-1, UTF-8 and UTF-16 bytes in, code units out.
// Depends on ted_pkg, ted_if, ted_front, ted_queue and ted_back.
//
// Usage:
//   in_ch carries one raw byte per item with bytes_left (1 marks the last
//   byte of a text). out_ch carries code units; last_of_run marks the final
//   unit caused by one byte. A byte may cause no unit, one unit, or two
//   (a surrogate pair when split_supplementary is set).
//   Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
//   (0 text_encoding, 1 split_supplementary) while the block is idle.
// Timing:
//   One byte is accepted every cycle while the four-entry job queue has room.
//   A byte's first unit passes through the queue, which takes its job at the
//   accepting edge, and then the output register, which loads it once the
//   back end is free. A pair leaves as two units through the single output
//   port, which sets the sustained rate.
// Reset: clears decode state and the queue; text_encoding returns to UTF-8
//   and split_supplementary to 1.
// Stall: when out_ch.ready is low the output unit holds; bytes keep flowing
//   in until the queue fills, then in_ch.ready drops.
module text_encoding_decoder import ted_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  ted_in_if.sink                in_ch,
  ted_out_if.source             out_ch
);

  cfg_t    cfg_q;
  logic    push;
  job_t    job;
  job_t    head;
  q_stat_t q_stat;
  logic    pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.encoding <= ENC_UTF8;
      cfg_q.split    <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IDX_ENCODING: cfg_q.encoding <= cfg_data_i;
        CFG_IDX_SPLIT:    cfg_q.split    <= cfg_data_i[0];
        default:          cfg_q          <= cfg_q;
      endcase
    end
  end

  ted_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .in_ch  (in_ch),
    .full_i (q_stat.full),
    .push_o (push),
    .job_o  (job)
  );

  ted_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job),
    .pop_i  (pop),
    .head_o (head),
    .stat_o (q_stat)
  );

  ted_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .stat_i (q_stat),
    .pop_o  (pop),
    .out_ch (out_ch)
  );

`ifndef ASSERT_OFF
  // a high surrogate is always followed by its low half
  a_pair_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && out_ch.ready && !out_ch.last_of_run
      |=> out_ch.valid && out_ch.last_of_run)
    else $error("surrogate pair broken");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_stat.full && in_ch.valid)
    else $error("push into full queue");
`endif

endmodule

// File: rtl/core/ted_front.sv
// Front end: accepts raw bytes, tracks UTF-8 / UTF-16 decode state and
// pushes each byte's results as one job into the queue. Uses ted_pkg, ted_in_if.
module ted_front import ted_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  ted_in_if.sink     in_ch,
  input  logic       full_i,
  output logic       push_o,
  output job_t       job_o
);

  logic [1:0]        pend_q, pend_d;
  logic [CODE_W-1:0] acc_q, acc_d;
  logic              discard_q, discard_d;
  logic [7:0]        held_q, held_d;
  logic              phase_q, phase_d;
  logic              first_q, first_d;
  logic              big_q, big_d;

  logic              accept;
  logic [LEFT_W-1:0] left_n;
  logic [7:0]        b;
  logic              emit;
  logic [CODE_W-1:0] pt;
  logic [CODE_W-1:0] v;
  logic [CODE_W-1:0] acc_shift;
  logic              lead_go;
  logic [2:0]        need;
  logic              lead_ok;
  logic              big;
  logic [15:0]       unit16;

  assign in_ch.ready = !full_i;
  assign accept      = in_ch.valid && !full_i;
  assign b           = in_ch.data_byte;
  assign acc_shift   = {acc_q[CODE_W-7:0], b[5:0]};

  always_comb begin
    if (in_ch.bytes_left == 3'd0) begin
      left_n = 3'd1;
    end else if (in_ch.bytes_left > 3'd4) begin
      left_n = 3'd4;
    end else begin
      left_n = in_ch.bytes_left;
    end
  end

  always_comb begin
    pend_d    = pend_q;
    acc_d     = acc_q;
    discard_d = discard_q;
    held_d    = held_q;
    phase_d   = phase_q;
    first_d   = first_q;
    big_d     = big_q;
    emit      = 1'b0;
    pt        = '0;
    lead_go   = 1'b0;
    need      = 3'd0;
    lead_ok   = 1'b0;
    big       = 1'b0;
    unit16    = '0;

    case (cfg_i.encoding)
      ENC_LATIN1: begin
        emit = 1'b1;
        pt   = {{(CODE_W-8){1'b0}}, b};
      end
      ENC_UTF8: begin
        if (!discard_q) begin
          if (pend_q != 2'd0) begin
            if ((b & UTF8_CONT_MASK) == UTF8_CONT_TAG) begin
              acc_d  = acc_shift;
              pend_d = pend_q - 2'd1;
              if (pend_q == 2'd1) begin
                emit = 1'b1;
                pt   = acc_shift;
              end
            end else begin
              // abandon the sequence, re-read this byte as a lead
              pend_d  = 2'd0;
              acc_d   = '0;
              lead_go = 1'b1;
            end
          end else begin
            lead_go = 1'b1;
          end
          if (lead_go) begin
            if (b[7] == 1'b0) begin
              emit = 1'b1;
              pt   = {{(CODE_W-8){1'b0}}, b};
            end else if ((b & UTF8_LEAD2_MASK) == UTF8_LEAD2_TAG) begin
              lead_ok = 1'b1;
              need    = 3'd2;
              acc_d   = {{(CODE_W-5){1'b0}}, b[4:0]};
            end else if ((b & UTF8_LEAD3_MASK) == UTF8_LEAD3_TAG) begin
              lead_ok = 1'b1;
              need    = 3'd3;
              acc_d   = {{(CODE_W-4){1'b0}}, b[3:0]};
            end else if ((b & UTF8_LEAD4_MASK) == UTF8_LEAD4_TAG) begin
              lead_ok = 1'b1;
              need    = 3'd4;
              acc_d   = {{(CODE_W-3){1'b0}}, b[2:0]};
            end
            if (lead_ok) begin
              if (need > left_n) begin
                discard_d = 1'b1;
                acc_d     = '0;
              end else begin
                pend_d = 2'(need - 3'd1);
              end
            end
          end
        end
      end
      default: begin
        if (!phase_q) begin
          held_d  = b;
          phase_d = 1'b1;
        end else begin
          phase_d = 1'b0;
          first_d = 1'b1;
          if (cfg_i.encoding == ENC_UTF16_BOM) begin
            if (!first_q) begin
              big   = (held_q == BOM_HI) && (b == BOM_LO);
              big_d = big;
            end else begin
              big = big_q;
            end
          end else begin
            big = (cfg_i.encoding == ENC_UTF16_BE);
          end
          unit16 = big ? {held_q, b} : {b, held_q};
          if (unit16 != UNIT_BOM && unit16 != UNIT_NONCHAR) begin
            emit = 1'b1;
            pt   = {{(CODE_W-16){1'b0}}, unit16};
          end
        end
      end
    endcase

    // end of text drops whatever is unfinished
    if (left_n == 3'd1) begin
      pend_d    = 2'd0;
      acc_d     = '0;
      discard_d = 1'b0;
      held_d    = '0;
      phase_d   = 1'b0;
      first_d   = 1'b0;
      big_d     = 1'b0;
    end
  end

  assign v = pt - SUPP_BASE;

  always_comb begin
    job_o.pair  = cfg_i.split && (pt > BMP_MAX);
    if (job_o.pair) begin
      job_o.unit0 = HI_SURR + {10'b0, v[CODE_W-1:10]};
      job_o.unit1 = LO_SURR + {11'b0, v[9:0]};
    end else begin
      job_o.unit0 = pt;
      job_o.unit1 = '0;
    end
  end

  assign push_o = accept && emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q    <= '0;
      acc_q     <= '0;
      discard_q <= 1'b0;
      held_q    <= '0;
      phase_q   <= 1'b0;
      first_q   <= 1'b0;
      big_q     <= 1'b0;
    end else if (accept) begin
      pend_q    <= pend_d;
      acc_q     <= acc_d;
      discard_q <= discard_d;
      held_q    <= held_d;
      phase_q   <= phase_d;
      first_q   <= first_d;
      big_q     <= big_d;
    end
  end

endmodule

// File: rtl/core/ted_queue.sv
// Short job queue between the decode front end and the output back end.
// Uses ted_pkg for job_t and the queue depth.
module ted_queue import ted_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  job_t    job_i,
  input  logic    pop_i,
  output job_t    head_o,
  output q_stat_t stat_o
);

  job_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push, do_pop;

  assign stat_o.full  = (cnt_q == QCNT_W'(QDEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + QPTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
        2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// File: rtl/core/ted_back.sv
// Back end: holds one job in the output register and delivers its one
// or two code units. Uses ted_pkg and ted_out_if.
module ted_back import ted_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  job_t    head_i,
  input  q_stat_t stat_i,
  output logic    pop_o,
  ted_out_if.source out_ch
);

  logic              busy_q, busy_d;
  logic              phase_q, phase_d;
  job_t              job_q;
  logic              fire;
  logic              take;

  assign out_ch.valid       = busy_q;
  assign out_ch.code_unit   = (job_q.pair && phase_q) ? job_q.unit1 : job_q.unit0;
  assign out_ch.last_of_run = !job_q.pair || phase_q;

  assign fire  = busy_q && out_ch.ready;
  // free the register when empty or when its final unit leaves
  assign take  = !busy_q || (fire && (!job_q.pair || phase_q));
  assign pop_o = take && !stat_i.empty;

  always_comb begin
    busy_d  = busy_q;
    phase_d = phase_q;
    if (pop_o) begin
      busy_d  = 1'b1;
      phase_d = 1'b0;
    end else if (take) begin
      busy_d  = 1'b0;
      phase_d = 1'b0;
    end else if (fire) begin
      phase_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= head_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      phase_q <= phase_d;
    end
  end

endmodule

// File: verif/tb_text_encoding_decoder.sv
// Testbench for text_encoding_decoder: directed and random byte texts in all encodings,
// checked unit by unit against an in-bench decoder model, with random stalls on both sides.
// Depends on ted_pkg, ted_if and the text_encoding_decoder RTL.
`timescale 1ns / 100ps

module tb_text_encoding_decoder;
  import ted_pkg::*;

  localparam int RANDOM_ITEMS    = 1080;
  localparam int STEADY_ITEMS    = 80;
  localparam int SETTLE_CYCLES   = 8;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int CYCLE_LIMIT     = 500000;
  localparam logic [7:0] ENC_UTF16_LE = 8'd4;

  typedef struct packed {
    logic [CODE_W-1:0] code_unit;
    logic              last_of_run;
  } code_unit_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  ted_in_if  in_ch ();
  ted_out_if out_ch ();

  text_encoding_decoder dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Decoder model: register copies and per-text state
  logic [7:0]        enc_reg;
  logic              split_reg;
  logic [1:0]        pend_cnt;
  logic [CODE_W-1:0] accum;
  logic              drop_text;
  logic [7:0]        first_byte;
  logic              have_first;
  logic              order_fixed;
  logic              order_big;

  code_unit_t expected_units[$];
  logic [7:0] text_buf[$];

  int  errors;
  int  bytes_sent;
  int  cycle_cnt;
  bit  tx_calm;
  bit  rx_calm;
  bit  hold_off_req;

  function automatic void clear_text_state();
    pend_cnt    = 2'd0;
    accum       = '0;
    drop_text   = 1'b0;
    first_byte  = 8'd0;
    have_first  = 1'b0;
    order_fixed = 1'b0;
    order_big   = 1'b0;
  endfunction

  function automatic void push_unit(input logic [CODE_W-1:0] cu, input logic last);
    code_unit_t u;
    u.code_unit   = cu;
    u.last_of_run = last;
    expected_units = {expected_units, u};
  endfunction

  // Split supplementary points into a surrogate pair when enabled
  function automatic void push_code_point(input logic [CODE_W-1:0] cp);
    logic [CODE_W-1:0] v;
    if (split_reg && cp > BMP_MAX) begin
      v = cp - SUPP_BASE;
      push_unit(HI_SURR + (v >> 10), 1'b0);
      push_unit(LO_SURR + {11'd0, v[9:0]}, 1'b1);
    end else begin
      push_unit(cp, 1'b1);
    end
  endfunction

  task automatic predict_units(input logic [7:0] b, input logic [2:0] left_raw);
    logic [2:0]  left;
    int          need;
    logic        big;
    logic [15:0] unit;
    left = (left_raw == 3'd0) ? 3'd1 : ((left_raw > 3'd4) ? 3'd4 : left_raw);
    need = 0;
    if (enc_reg == ENC_LATIN1) begin
      push_unit({13'd0, b}, 1'b1);
    end else if (enc_reg == ENC_UTF8) begin
      if (!drop_text) begin
        if (pend_cnt != 2'd0 && (b & UTF8_CONT_MASK) == UTF8_CONT_TAG) begin
          accum = {accum[CODE_W-7:0], b[5:0]};
          pend_cnt = pend_cnt - 2'd1;
          if (pend_cnt == 2'd0) push_code_point(accum);
        end else begin
          // abandon any pending sequence and read this byte as a lead
          pend_cnt = 2'd0;
          if (!b[7]) push_code_point({13'd0, b});
          else if ((b & UTF8_LEAD2_MASK) == UTF8_LEAD2_TAG) begin
            accum = {16'd0, b[4:0]};
            need = 2;
          end else if ((b & UTF8_LEAD3_MASK) == UTF8_LEAD3_TAG) begin
            accum = {17'd0, b[3:0]};
            need = 3;
          end else if ((b & UTF8_LEAD4_MASK) == UTF8_LEAD4_TAG) begin
            accum = {18'd0, b[2:0]};
            need = 4;
          end
          if (need > int'(left)) begin
            drop_text = 1'b1;
            accum = '0;
          end else if (need != 0) begin
            pend_cnt = 2'(need - 1);
          end
        end
      end
    end else begin
      if (!have_first) begin
        first_byte = b;
        have_first = 1'b1;
      end else begin
        have_first = 1'b0;
        if (enc_reg == ENC_UTF16_BOM) begin
          if (!order_fixed) order_big = (first_byte == BOM_HI && b == BOM_LO);
          big = order_big;
        end else begin
          big = (enc_reg == ENC_UTF16_BE);
        end
        order_fixed = 1'b1;
        unit = big ? {first_byte, b} : {b, first_byte};
        if (unit != UNIT_BOM && unit != UNIT_NONCHAR) push_unit({5'd0, unit}, 1'b1);
      end
    end
    if (left == 3'd1) clear_text_state();
  endtask

  // Check each accepted unit against the oldest expectation
  always @(posedge clk_i) begin : unit_checker
    code_unit_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_units.size() == 0) begin
        $display("%0t: unexpected unit, expected none, actual code_unit %h last_of_run %b",
                 $time, out_ch.code_unit, out_ch.last_of_run);
        errors++;
      end else begin
        want = expected_units.pop_front();
        if (out_ch.code_unit !== want.code_unit) begin
          $display("%0t: code_unit expected %h actual %h", $time, want.code_unit,
                   out_ch.code_unit);
          errors++;
        end
        if (out_ch.last_of_run !== want.last_of_run) begin
          $display("%0t: last_of_run expected %b actual %b", $time, want.last_of_run,
                   out_ch.last_of_run);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Output side: random stall bursts, calm windows, and a long hold-off on request
  initial begin : output_sink
    int n;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk_i);
        hold_off_req = 1'b0;
        out_ch.ready <= 1'b1;
      end else if (!rx_calm && $urandom_range(0, 11) == 0) begin
        out_ch.ready <= 1'b0;
        n = $urandom_range(1, 19);
        repeat (n) @(negedge clk_i);
        out_ch.ready <= 1'b1;
      end else if ($urandom_range(0, 23) == 0) begin
        out_ch.ready <= 1'b1;
        n = $urandom_range(20, 80);
        repeat (n) @(negedge clk_i);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Offer one item; call at a falling edge. Returns at a falling edge with valid still
  // high unless a gap was taken, so the caller sends again or drops valid at once.
  task automatic send_byte(input logic [7:0] b, input logic [2:0] left);
    int gap;
    in_ch.valid      <= 1'b1;
    in_ch.data_byte  <= b;
    in_ch.bytes_left <= left;
    do @(posedge clk_i); while (!in_ch.ready);
    predict_units(b, left);
    bytes_sent++;
    @(negedge clk_i);
    gap = (!tx_calm && $urandom_range(0, 9) == 0) ? $urandom_range(1, 19) : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (expected_units.size() != 0) @(negedge clk_i);
    // let bytes that cause no unit clear the pipeline
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    wait_idle();
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    if (idx == CFG_IDX_ENCODING) enc_reg = val;
    else split_reg = val[0];
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic set_split(input logic s);
    set_reg(CFG_IDX_SPLIT, {7'($urandom), s});
  endtask

  // Send text_buf as one text; jitter bends bytes_left out of range or to random values, cut stops early
  task automatic send_text(input bit jitter, input bit cut);
    int         n;
    int         stop;
    logic [2:0] left;
    n = text_buf.size();
    stop = cut ? $urandom_range(0, n - 1) : n;
    for (int i = 0; i < stop; i++) begin
      left = (n - i >= 4) ? 3'd4 : 3'(n - i);
      if (jitter && $urandom_range(0, 15) == 0) begin
        if (n - i >= 4) left = 3'($urandom_range(4, 7));
        else if (n - i == 1) left = 3'd0;
      end else if (jitter && $urandom_range(0, 63) == 0) begin
        left = 3'($urandom_range(0, 7));
      end
      send_byte(text_buf[i], left);
    end
  endtask

  task automatic build_text(input logic [7:0] enc);
    int          n;
    logic [20:0] cp;
    text_buf.delete();
    n = $urandom_range(1, 10);
    if (enc == ENC_UTF8) begin
      for (int c = 0; c < n; c++) begin
        cp = 21'($urandom);
        if ($urandom_range(0, 6) == 0) begin
          text_buf = {text_buf, 8'($urandom_range(0, 255))};
        end else begin
          case ($urandom_range(1, 4))
            1: text_buf = {text_buf, {1'b0, cp[6:0]}};
            2: begin
              text_buf = {text_buf, {3'b110, cp[10:6]}};
              text_buf = {text_buf, {2'b10, cp[5:0]}};
            end
            3: begin
              text_buf = {text_buf, {4'b1110, cp[15:12]}};
              text_buf = {text_buf, {2'b10, cp[11:6]}};
              text_buf = {text_buf, {2'b10, cp[5:0]}};
            end
            default: begin
              text_buf = {text_buf, {5'b11110, cp[20:18]}};
              text_buf = {text_buf, {2'b10, cp[17:12]}};
              text_buf = {text_buf, {2'b10, cp[11:6]}};
              text_buf = {text_buf, {2'b10, cp[5:0]}};
            end
          endcase
        end
      end
      // drop the final byte now and then so the last sequence overruns the text
      if ($urandom_range(0, 7) == 0 && text_buf.size() > 1) text_buf = text_buf[0:$-1];
    end else if (enc == ENC_LATIN1) begin
      repeat (n) text_buf = {text_buf, 8'($urandom_range(0, 255))};
    end else begin
      if ($urandom_range(0, 2) == 0) begin
        if ($urandom_range(0, 1) == 0) begin
          text_buf = {text_buf, BOM_HI, BOM_LO};
        end else begin
          text_buf = {text_buf, BOM_LO, BOM_HI};
        end
      end
      repeat (n) begin
        if ($urandom_range(0, 9) == 0) begin
          text_buf = {text_buf, ($urandom_range(0, 1) ? BOM_HI : BOM_LO)};
          text_buf = {text_buf, ($urandom_range(0, 1) ? BOM_HI : BOM_LO)};
        end else begin
          text_buf = {text_buf, 8'($urandom_range(0, 255))};
          text_buf = {text_buf, 8'($urandom_range(0, 255))};
        end
      end
      if ($urandom_range(0, 3) == 0) text_buf = {text_buf, 8'($urandom_range(0, 255))};
    end
  endtask

  task automatic test_utf8_basics();
    // reset config: UTF-8 with splitting; a pair, a bad continuation, an invalid lead
    text_buf = '{8'hf0, 8'h9f, 8'h98, 8'h80, 8'hc3, 8'h41, 8'hff};
    send_text(1'b0, 1'b0);
    // largest four-byte point whole, then a lead that overruns the text
    set_split(1'b0);
    text_buf = '{8'hf7, 8'hbf, 8'hbf, 8'hbf, 8'he2, 8'h82};
    send_text(1'b0, 1'b0);
  endtask

  task automatic test_latin1_passthrough();
    set_reg(CFG_IDX_ENCODING, ENC_LATIN1);
    send_byte(8'h00, 3'd7);
    send_byte(8'hff, 3'd5);
    send_byte(8'h80, 3'd0);
  endtask

  task automatic test_utf16_order_mark();
    set_reg(CFG_IDX_ENCODING, ENC_UTF16_BOM);
    // big endian mark, then a dropped FFFE unit
    text_buf = '{8'hfe, 8'hff, 8'h00, 8'h41, 8'hff, 8'hfe};
    send_text(1'b0, 1'b0);
    // little endian by default, odd final byte dropped
    text_buf = '{8'hff, 8'hfe, 8'h41, 8'h00, 8'h7a};
    send_text(1'b0, 1'b0);
  endtask

  task automatic test_random_texts();
    logic [7:0] enc;
    int         texts;
    while (bytes_sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 8))
        0:       enc = ENC_LATIN1;
        1:       enc = ENC_UTF16_BOM;
        2:       enc = ENC_UTF16_BE;
        3, 4, 5: enc = ENC_UTF8;
        6:       enc = ENC_UTF16_LE;
        7:       enc = 8'hff;
        default: enc = 8'($urandom_range(0, 255));
      endcase
      set_reg(CFG_IDX_ENCODING, enc);
      set_split(1'($urandom_range(0, 1)));
      tx_calm = ($urandom_range(0, 3) == 0);
      texts = $urandom_range(4, 10);
      for (int t = 0; t < texts; t++) begin
        build_text(enc);
        // leave the last text unfinished now and then so the next setting lands mid-text
        send_text(1'b1, t == texts - 1 && $urandom_range(0, 2) == 0);
      end
      tx_calm = 1'b0;
    end
  endtask

  task automatic test_output_stall();
    set_reg(CFG_IDX_ENCODING, ENC_UTF8);
    set_split(1'b1);
    hold_off_req = 1'b1;
    tx_calm = 1'b1;
    // four-byte points keep the job queue filling while the output holds
    text_buf.delete();
    repeat (6) text_buf = {text_buf, 8'hf0, 8'h9f, 8'h98, 8'h80};
    send_text(1'b0, 1'b0);
    tx_calm = 1'b0;
    wait_idle();
    build_text(ENC_UTF8);
    send_text(1'b1, 1'b0);
  endtask

  task automatic test_steady_stream();
    int stop_at;
    tx_calm = 1'b1;
    rx_calm = 1'b1;
    set_reg(CFG_IDX_ENCODING, ENC_UTF8);
    set_split(1'b1);
    stop_at = bytes_sent + STEADY_ITEMS;
    while (bytes_sent < stop_at) begin
      build_text(ENC_UTF8);
      send_text(1'b1, 1'b0);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.bytes_left = 3'd1;
    errors = 0;
    bytes_sent = 0;
    cycle_cnt = 0;
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    hold_off_req = 1'b0;
    enc_reg = ENC_UTF8;
    split_reg = 1'b1;
    clear_text_state();
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_utf8_basics();
    test_latin1_passthrough();
    test_utf16_order_mark();
    test_random_texts();
    test_output_stall();
    test_steady_stream();

    wait_idle();
    repeat (10) @(negedge clk_i);
    if (expected_units.size() != 0) begin
      $display("%0t: %0d units expected, actual none", $time, expected_units.size());
      errors++;
    end
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
